>>> rtl/chh_pkg.sv
// ----------------------------------------------------------------------------
// chh_pkg
// Shared types, constants and the arctangent table of the compass heading
// and hard-iron calibration unit.
// ----------------------------------------------------------------------------
package chh_pkg;

    // Raw sample and offset width.
    localparam int RAW_W = 16;
    // Sample minus offset.
    localparam int DIFF_W = RAW_W + 1;
    // The CORDIC vector is scaled up by 2^14 before the iterations start.
    localparam int PRESCALE_SH = 14;
    // Vector registers hold the prescaled difference plus the CORDIC gain.
    localparam int XY_W = 34;
    // Angle in degrees with 20 fraction bits, signed.
    localparam int Z_W = 31;
    localparam int FRAC_BITS = 20;
    localparam int HEAD_W = 9;
    // Index into the arctangent table (24 entries).
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [Z_W-1:0] DEG_FULL     = Z_W'(360 * (2 ** FRAC_BITS));
    localparam logic signed [Z_W-1:0] DEG_HALF     = Z_W'(180 * (2 ** FRAC_BITS));
    localparam logic signed [Z_W-1:0] DEG_QUARTER  = Z_W'(90 * (2 ** FRAC_BITS));
    localparam logic signed [Z_W-1:0] DEG_3QUARTER = Z_W'(270 * (2 ** FRAC_BITS));

    // Item kinds carried in the mode field.
    localparam logic [1:0] MODE_SAMPLE    = 2'd0;
    localparam logic [1:0] MODE_CAL_START = 2'd1;
    localparam logic [1:0] MODE_CAL_END   = 2'd2;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic                  take;   // item beat accepted this cycle
        logic                  prep;   // load the CORDIC vector
        logic                  step;   // one vectoring iteration
        logic                  emit;   // load the result register
        logic [ATAN_IDX_W-1:0] idx;    // current iteration
    } chh_cmd_t;

    // atan(2^-i) in degrees, 20 fraction bits.
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [ATAN_IDX_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            5'd0:  v = Z_W'(47185920);
            5'd1:  v = Z_W'(27855475);
            5'd2:  v = Z_W'(14718068);
            5'd3:  v = Z_W'(7471121);
            5'd4:  v = Z_W'(3750058);
            5'd5:  v = Z_W'(1876857);
            5'd6:  v = Z_W'(938658);
            5'd7:  v = Z_W'(469357);
            5'd8:  v = Z_W'(234682);
            5'd9:  v = Z_W'(117342);
            5'd10: v = Z_W'(58671);
            5'd11: v = Z_W'(29335);
            5'd12: v = Z_W'(14668);
            5'd13: v = Z_W'(7334);
            5'd14: v = Z_W'(3667);
            5'd15: v = Z_W'(1833);
            5'd16: v = Z_W'(917);
            5'd17: v = Z_W'(458);
            5'd18: v = Z_W'(229);
            5'd19: v = Z_W'(115);
            5'd20: v = Z_W'(57);
            5'd21: v = Z_W'(29);
            5'd22: v = Z_W'(14);
            5'd23: v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/chh_intf.sv
// ----------------------------------------------------------------------------
// chh_in_if / chh_out_if
// Valid/ready channels carrying magnetometer items in and heading results out.
// ----------------------------------------------------------------------------
interface chh_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;

    modport source (output valid, output mode, output mag_x, output mag_y,
                    output mag_z, input ready);
    modport sink   (input valid, input mode, input mag_x, input mag_y,
                    input mag_z, output ready);
endinterface

interface chh_out_if;
    logic               valid;
    logic               ready;
    logic [8:0]         heading_deg;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] offset_z;
    logic               is_calibrating;

    modport source (output valid, output heading_deg, output offset_x,
                    output offset_y, output offset_z, output is_calibrating,
                    input ready);
    modport sink   (input valid, input heading_deg, input offset_x,
                    input offset_y, input offset_z, input is_calibrating,
                    output ready);
endinterface

>>> rtl/chh_ctrl.sv
// ----------------------------------------------------------------------------
// chh_ctrl
// Sequencer: accepts an item, walks the CORDIC iterations and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module chh_ctrl import chh_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    output logic     result_valid,
    input  logic     result_ready,
    output chh_cmd_t cmd
);

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              last_step;

    assign out_free  = !out_valid_reg || result_ready;
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.take   = 1'b0;
        cmd.prep   = 1'b0;
        cmd.step   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.idx    = ATAN_IDX_W'(step_reg);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (last_step)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                // Wait here while the previous result beat is still pending.
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

>>> rtl/chh_datapath.sv
// ----------------------------------------------------------------------------
// chh_datapath
// Calibration state, offset arithmetic, iterative CORDIC atan2 and the
// result register.
// ----------------------------------------------------------------------------
module chh_datapath import chh_pkg::*; #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  chh_cmd_t                 cmd,
    input  logic [1:0]               mode,
    input  logic signed [RAW_W-1:0]  mag_x,
    input  logic signed [RAW_W-1:0]  mag_y,
    input  logic signed [RAW_W-1:0]  mag_z,
    output logic [HEAD_W-1:0]        heading_deg,
    output logic signed [RAW_W-1:0]  offset_x,
    output logic signed [RAW_W-1:0]  offset_y,
    output logic signed [RAW_W-1:0]  offset_z,
    output logic                     is_calibrating
);

    localparam int EXT = RAW_W - SAMPLE_BITS;

    logic signed [RAW_W-1:0]  raw_in [3];
    logic signed [RAW_W-1:0]  raw_shl [3];
    logic signed [RAW_W-1:0]  sample_in [3];
    logic signed [RAW_W:0]    mm_sum [3];
    logic signed [RAW_W:0]    mm_half [3];

    logic signed [RAW_W-1:0]  last_reg [3];
    logic signed [RAW_W-1:0]  min_reg [3];
    logic signed [RAW_W-1:0]  max_reg [3];
    logic signed [RAW_W-1:0]  ofs_reg [3];
    logic                     cal_reg;

    logic signed [DIFF_W-1:0] dx, dy;
    logic signed [XY_W-1:0]   x0, y0;
    logic signed [XY_W-1:0]   x_reg, y_reg, x_next, y_next;
    logic signed [XY_W-1:0]   xs, ys;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     exact_reg, exact_next;
    logic signed [Z_W-1:0]    atan_val;
    logic signed [Z_W-1:0]    z_wrap;
    logic signed [Z_W-1:0]    z_rev;

    logic [HEAD_W-1:0]        head_reg;
    logic signed [RAW_W-1:0]  ox_reg, oy_reg, oz_reg;
    logic                     cal_out_reg;

    assign raw_in[0] = mag_x;
    assign raw_in[1] = mag_y;
    assign raw_in[2] = mag_z;

    // Keep the low SAMPLE_BITS of each reading and sign-extend them.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            raw_shl[a]   = raw_in[a] <<< EXT;
            sample_in[a] = raw_shl[a] >>> EXT;
            mm_sum[a]    = DIFF_W'(max_reg[a]) + DIFF_W'(min_reg[a]);
            // Halve toward zero: a negative odd sum is bumped up first.
            mm_half[a]   = (mm_sum[a] + $signed({{RAW_W{1'b0}}, mm_sum[a][RAW_W]})) >>> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                last_reg[a] <= '0;
                min_reg[a]  <= '0;
                max_reg[a]  <= '0;
                ofs_reg[a]  <= '0;
            end
            cal_reg <= 1'b0;
        end
        else if (cmd.take)
        begin
            unique case (mode)
                MODE_SAMPLE:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        last_reg[a] <= sample_in[a];
                        if (cal_reg && (sample_in[a] < min_reg[a]))
                        begin
                            min_reg[a] <= sample_in[a];
                        end
                        if (cal_reg && (sample_in[a] > max_reg[a]))
                        begin
                            max_reg[a] <= sample_in[a];
                        end
                    end
                end
                MODE_CAL_START:
                begin
                    cal_reg <= 1'b1;
                    for (int a = 0; a < 3; a++)
                    begin
                        min_reg[a] <= last_reg[a];
                        max_reg[a] <= last_reg[a];
                    end
                end
                MODE_CAL_END:
                begin
                    cal_reg <= 1'b0;
                    for (int a = 0; a < 3; a++)
                    begin
                        ofs_reg[a] <= mm_half[a][RAW_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // CORDIC vectoring.
    assign dx       = DIFF_W'(last_reg[0]) - DIFF_W'(ofs_reg[0]);
    assign dy       = DIFF_W'(last_reg[1]) - DIFF_W'(ofs_reg[1]);
    assign x0       = XY_W'(dx) <<< PRESCALE_SH;
    assign y0       = XY_W'(dy) <<< PRESCALE_SH;
    assign xs       = x_reg >>> cmd.idx;
    assign ys       = y_reg >>> cmd.idx;
    assign atan_val = atan_q20(cmd.idx);

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        exact_next = exact_reg;
        if (cmd.prep)
        begin
            exact_next = 1'b0;
            x_next     = x0;
            y_next     = y0;
            z_next     = '0;
            // Vectors on an axis get their angle directly and skip the iterations.
            if (dy == '0)
            begin
                exact_next = 1'b1;
                z_next     = dx[DIFF_W-1] ? DEG_HALF : '0;
            end
            else if (dx == '0)
            begin
                exact_next = 1'b1;
                z_next     = dy[DIFF_W-1] ? DEG_3QUARTER : DEG_QUARTER;
            end
            else if (dx[DIFF_W-1])
            begin
                x_next = -x0;
                y_next = -y0;
                z_next = DEG_HALF;
            end
        end
        else if (cmd.step && !exact_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_val;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        exact_reg <= exact_next;
    end

    // The angle is never beyond a full turn, so one correction wraps it.
    assign z_wrap = z_reg[Z_W-1] ? (z_reg + DEG_FULL) : z_reg;
    assign z_rev  = DEG_FULL - z_wrap;

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            head_reg    <= z_rev[FRAC_BITS +: HEAD_W];
            ox_reg      <= ofs_reg[0];
            oy_reg      <= ofs_reg[1];
            oz_reg      <= ofs_reg[2];
            cal_out_reg <= cal_reg;
        end
    end

    assign heading_deg    = head_reg;
    assign offset_x       = ox_reg;
    assign offset_y       = oy_reg;
    assign offset_z       = oz_reg;
    assign is_calibrating = cal_out_reg;

endmodule

>>> rtl/compass_heading_hard_iron_cal_unit.sv
// ----------------------------------------------------------------------------
// compass_heading_hard_iron_cal_unit
// Hard-iron calibration of a three-axis magnetometer and heading by CORDIC.
// ----------------------------------------------------------------------------
// An accepted item beat passes through the PREP, RUN and EMIT states before its
// result beat is valid; one CORDIC iteration runs per cycle in the shared unit.
// A new item is taken only once the previous one has been emitted;
// a finished result waits in the output register while the next item runs.
// Reset: asynchronous; clears samples, min/max, offsets and calibration flag.
module compass_heading_hard_iron_cal_unit import chh_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    chh_in_if.sink     item,
    chh_out_if.source  result
);

    chh_cmd_t cmd;

    chh_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    chh_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (item.mode),
        .mag_x          (item.mag_x),
        .mag_y          (item.mag_y),
        .mag_z          (item.mag_z),
        .heading_deg    (result.heading_deg),
        .offset_x       (result.offset_x),
        .offset_y       (result.offset_y),
        .offset_z       (result.offset_z),
        .is_calibrating (result.is_calibrating)
    );

`ifndef ASSERT_OFF
    // An accepted beat is always followed by loading the CORDIC vector.
    a_take_then_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |=> cmd.prep)
        else $error("accepted item not followed by CORDIC load");

    // The sequencer issues at most one command per cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take, cmd.prep, cmd.step, cmd.emit}))
        else $error("more than one sequencer command active");

    // A new result never overwrites a beat that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!result.valid || result.ready))
        else $error("result register overwritten while pending");

    // Heading always lies in 0..360.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.heading_deg <= 9'd360))
        else $error("heading out of range");
`endif

endmodule

>>> dv/heading_cal_checker.sv
// ----------------------------------------------------------------------------
// heading_cal_checker
// Watches the item and result channels of the compass heading unit, keeps its
// own copy of the calibration state, works out the heading and offsets each
// accepted item must produce and compares them with the result beats in order.
// ----------------------------------------------------------------------------
module heading_cal_checker import chh_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    chh_in_if    item,
    chh_out_if   result,
    output int   fail_count,
    output int   checked_count,
    output int   pending_count
);

    localparam int CORDIC_STEPS = 16;
    localparam int SAMPLE_BITS  = 16;
    localparam int ANGLE_FRAC   = 20;
    localparam int ROTATIONS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

    localparam longint FULL_TURN_Q20    = 64'sd360 <<< ANGLE_FRAC;
    localparam longint HALF_TURN_Q20    = 64'sd180 <<< ANGLE_FRAC;
    localparam longint QUARTER_TURN_Q20 = 64'sd90 <<< ANGLE_FRAC;
    localparam longint THREE_QTR_Q20    = 64'sd270 <<< ANGLE_FRAC;

    typedef struct packed {
        logic [HEAD_W-1:0]       heading;
        logic signed [RAW_W-1:0] off_x;
        logic signed [RAW_W-1:0] off_y;
        logic signed [RAW_W-1:0] off_z;
        logic                    calibrating;
    } heading_beat_t;

    // Arctangent of 2^-i in degrees with 20 fraction bits.
    longint atan_deg_q20 [24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    logic signed [RAW_W-1:0] last_smp [3];
    logic signed [RAW_W-1:0] ax_min   [3];
    logic signed [RAW_W-1:0] ax_max   [3];
    logic signed [RAW_W-1:0] ax_off   [3];
    logic                    cal_on;

    heading_beat_t expected_headings [$];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Vectoring CORDIC on the offset-corrected x/y; vectors on an axis are exact.
    function automatic longint bearing_q20(input longint dx, input longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        if (dy == 0)
            return (dx < 0) ? HALF_TURN_Q20 : 0;
        if (dx == 0)
            return (dy > 0) ? QUARTER_TURN_Q20 : THREE_QTR_Q20;
        x = dx <<< PRESCALE_SH;
        y = dy <<< PRESCALE_SH;
        z = 0;
        if (dx < 0)
        begin
            x = -x;
            y = -y;
            z = HALF_TURN_Q20;
        end
        for (int i = 0; i < ROTATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_deg_q20[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_deg_q20[i];
            end
        end
        if (z < 0)
            z = z + FULL_TURN_Q20;
        if (z >= FULL_TURN_Q20)
            z = z - FULL_TURN_Q20;
        return z;
    endfunction

    task automatic apply_item(input logic [1:0] mode, input logic [RAW_W-1:0] mx,
                              input logic [RAW_W-1:0] my, input logic [RAW_W-1:0] mz,
                              output heading_beat_t want);
        logic [RAW_W-1:0] raw [3];
        longint           bearing;
        raw[0] = mx;
        raw[1] = my;
        raw[2] = mz;
        case (mode)
            MODE_SAMPLE:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    // Only the low SAMPLE_BITS of a reading count, sign-extended.
                    last_smp[a] = $signed(raw[a] << (RAW_W - SAMPLE_BITS))
                                  >>> (RAW_W - SAMPLE_BITS);
                    if (cal_on)
                    begin
                        if (last_smp[a] < ax_min[a])
                            ax_min[a] = last_smp[a];
                        if (last_smp[a] > ax_max[a])
                            ax_max[a] = last_smp[a];
                    end
                end
            end
            MODE_CAL_START:
            begin
                cal_on = 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    ax_min[a] = last_smp[a];
                    ax_max[a] = last_smp[a];
                end
            end
            MODE_CAL_END:
            begin
                cal_on = 1'b0;
                // Signed integer division truncates toward zero.
                for (int a = 0; a < 3; a++)
                    ax_off[a] = RAW_W'((int'(ax_max[a]) + int'(ax_min[a])) / 2);
            end
            default:
            begin
            end
        endcase
        bearing = bearing_q20(longint'(last_smp[0]) - longint'(ax_off[0]),
                              longint'(last_smp[1]) - longint'(ax_off[1]));
        want.heading     = HEAD_W'((FULL_TURN_Q20 - bearing) >>> ANGLE_FRAC);
        want.off_x       = ax_off[0];
        want.off_y       = ax_off[1];
        want.off_z       = ax_off[2];
        want.calibrating = cal_on;
    endtask

    always @(posedge clk)
    begin : watch
        heading_beat_t want;
        heading_beat_t got;
        heading_beat_t next_want;
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                last_smp[a] = '0;
                ax_min[a]   = '0;
                ax_max[a]   = '0;
                ax_off[a]   = '0;
            end
            cal_on = 1'b0;
            expected_headings.delete();
            fail_count    = 0;
            checked_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.heading     = result.heading_deg;
                got.off_x       = result.offset_x;
                got.off_y       = result.offset_y;
                got.off_z       = result.offset_z;
                got.calibrating = result.is_calibrating;
                if (expected_headings.size() == 0)
                    report_mismatch($sformatf("result beat (heading %0d) with nothing expected",
                                              got.heading));
                else
                begin
                    want = expected_headings.pop_front();
                    checked_count++;
                    if (got.heading !== want.heading)
                        report_mismatch($sformatf("heading_deg %0d, expected %0d",
                                                  got.heading, want.heading));
                    if (got.off_x !== want.off_x)
                        report_mismatch($sformatf("offset_x %0d, expected %0d",
                                                  got.off_x, want.off_x));
                    if (got.off_y !== want.off_y)
                        report_mismatch($sformatf("offset_y %0d, expected %0d",
                                                  got.off_y, want.off_y));
                    if (got.off_z !== want.off_z)
                        report_mismatch($sformatf("offset_z %0d, expected %0d",
                                                  got.off_z, want.off_z));
                    if (got.calibrating !== want.calibrating)
                        report_mismatch($sformatf("is_calibrating %0b, expected %0b",
                                                  got.calibrating, want.calibrating));
                end
            end
            if (item.valid && item.ready)
            begin
                apply_item(item.mode, item.mag_x, item.mag_y, item.mag_z, next_want);
                expected_headings.push_back(next_want);
            end
            pending_count = expected_headings.size();
        end
    end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives magnetometer samples and calibration events into the compass heading
// unit under varying sender and receiver idling, including long receiver
// hold-offs, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_top import chh_pkg::*; ();

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int src_idle_pct  = 34;
    int sink_idle_pct = 64;
    bit hold_off_req  = 1'b0;

    int n_samples;
    int n_starts;
    int n_ends;
    int n_ignored;
    int n_holds;

    int fail_count;
    int checked_count;
    int pending_count;

    always #5 clk = ~clk;

    chh_in_if  item_ch ();
    chh_out_if result_ch ();

    compass_heading_hard_iron_cal_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    heading_cal_checker u_heading_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .checked_count (checked_count),
        .pending_count (pending_count)
    );

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_item(input logic [1:0] mode, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.mode  = mode;
        item_ch.mag_x = x;
        item_ch.mag_y = y;
        item_ch.mag_z = z;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
        case (mode)
            MODE_SAMPLE:    n_samples++;
            MODE_CAL_START: n_starts++;
            MODE_CAL_END:   n_ends++;
            default:        n_ignored++;
        endcase
    endtask

    function automatic logic [15:0] pick_axis(input int span);
        case ($urandom_range(7))
            0, 1, 2: return 16'($urandom);
            3:
            begin
                case ($urandom_range(4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            default: return 16'(int'($urandom_range(2 * span)) - span);
        endcase
    endfunction

    task automatic send_event(input logic [1:0] mode);
        send_item(mode, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_sample(input int span);
        send_item(MODE_SAMPLE, pick_axis(span), pick_axis(span), pick_axis(span));
    endtask

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
                result_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int plain_items;
        int span;
        int burst;
        int next_hold_at;
        int pick;
        item_ch.valid = 1'b0;
        item_ch.mode  = MODE_SAMPLE;
        item_ch.mag_x = '0;
        item_ch.mag_y = '0;
        item_ch.mag_z = '0;
        plain_items  = 0;
        span         = 8;
        next_hold_at = 300;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Vectors on each axis, the zero vector, diagonals and full-scale readings.
        send_item(MODE_SAMPLE, 16'd0, 16'd0, 16'd0);
        send_item(MODE_SAMPLE, 16'd100, 16'd0, 16'd5);
        send_item(MODE_SAMPLE, -16'sd100, 16'd0, -16'sd5);
        send_item(MODE_SAMPLE, 16'd0, 16'd100, 16'd0);
        send_item(MODE_SAMPLE, 16'd0, -16'sd100, 16'd0);
        send_item(MODE_SAMPLE, 16'd1, 16'd1, 16'd1);
        send_item(MODE_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        send_item(MODE_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000);
        send_item(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF);
        // An end with no start in front of it, then the unused mode.
        send_event(MODE_CAL_END);
        send_event(MODE_IGNORED);
        // Offsets of (0 + -3) / 2 must truncate to -1, so the next vector is zero.
        send_item(MODE_SAMPLE, -16'sd3, -16'sd3, -16'sd3);
        send_event(MODE_CAL_START);
        send_item(MODE_SAMPLE, 16'd0, 16'd0, 16'd0);
        send_event(MODE_IGNORED);
        send_event(MODE_CAL_END);
        send_item(MODE_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_SAMPLE, 16'hFFFF, 16'd5, 16'd0);
        // Most negative offsets, reached through a start while already active.
        send_item(MODE_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        send_event(MODE_CAL_START);
        send_event(MODE_CAL_START);
        send_event(MODE_CAL_END);
        send_item(MODE_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(MODE_SAMPLE, 16'h8000, 16'h7FFF, 16'h7FFF);

        while (plain_items < RANDOM_ITEMS)
        begin
            if (plain_items < RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 34;
                sink_idle_pct = 64;
            end
            else if (plain_items < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 64;
                sink_idle_pct = 34;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (plain_items >= next_hold_at)
            begin
                hold_off_req = 1'b1;
                n_holds++;
                next_hold_at += 900;
            end
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                send_sample(span);
                plain_items++;
            end
            else if (pick < 85)
            begin
                // A full calibration pass at a freshly chosen spread.
                case ($urandom_range(2))
                    0:       span = 8;
                    1:       span = 300;
                    default: span = 32767;
                endcase
                burst = $urandom_range(2, 20);
                send_event(MODE_CAL_START);
                repeat (burst)
                    send_sample(span);
                send_event(MODE_CAL_END);
                plain_items += burst + 2;
            end
            else if (pick < 90)
                send_event(MODE_IGNORED);
            else if (pick < 94)
            begin
                send_event(MODE_CAL_END);
                plain_items++;
            end
            else if (pick < 97)
            begin
                send_event(MODE_CAL_START);
                plain_items++;
            end
            else
            begin
                // Broken pass: restarted in the middle, noise mixed in.
                send_event(MODE_CAL_START);
                send_sample(span);
                send_event(MODE_IGNORED);
                send_event(MODE_CAL_START);
                send_sample(span);
                send_sample(span);
                send_event(MODE_CAL_END);
                plain_items += 6;
            end
        end
        item_ch.valid = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Covered %0d samples, %0d calibration starts, %0d ends, %0d ignored-mode items.",
                 n_samples, n_starts, n_ends, n_ignored);
        $display("Compared %0d result beats over three idling phases and %0d long hold-offs.",
                 checked_count, n_holds);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
